/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the SOCKS request parser.
// No dependencies; included by socks_request_parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in socks request parser");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   `ASSERT_PROP(lbl, clk, rst, !(cond))

`endif

/* hw/rtl/srp_pkg.sv */
// Package for the SOCKS request parser: status codes, protocol bytes,
// address kinds and parse phases. No dependencies.
`default_nettype none

package srp_pkg;

   typedef enum logic [2:0] {
      ST_CONSUMED = 3'd0,
      ST_METHODS  = 3'd1,
      ST_COMPLETE = 3'd2,
      ST_ERROR    = 3'd3,
      ST_PAYLOAD  = 3'd4
   } status_type;

   // address kinds reported on address_type
   localparam logic [2:0] ATYP_UNKNOWN = 3'd0;
   localparam logic [2:0] ATYP_IPV4    = 3'd1;
   localparam logic [2:0] ATYP_DOMAIN  = 3'd3;
   localparam logic [2:0] ATYP_IPV6    = 3'd4;

   // versions reported on socks_version
   localparam logic [2:0] VER_NONE = 3'd0;
   localparam logic [2:0] VER_4    = 3'd4;
   localparam logic [2:0] VER_5    = 3'd5;

   // protocol bytes
   localparam logic [7:0] BYTE_VER4        = 8'h04;
   localparam logic [7:0] BYTE_VER5        = 8'h05;
   localparam logic [7:0] BYTE_CMD_CONNECT = 8'h01;
   localparam logic [7:0] BYTE_ATYP_IPV4   = 8'h01;
   localparam logic [7:0] BYTE_ATYP_DOMAIN = 8'h03;
   localparam logic [7:0] BYTE_ATYP_IPV6   = 8'h04;
   localparam logic [7:0] BYTE_NOAUTH      = 8'h00;
   localparam logic [7:0] BYTE_ZERO        = 8'h00;

   localparam logic [7:0] IPV4_ADDR_LEN = 8'd4;
   localparam logic [7:0] IPV6_ADDR_LEN = 8'd16;
   localparam logic [7:0] PORT_BYTES    = 8'd2;
   localparam logic [7:0] IPV4_PREFIX_LEN = 8'd3;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_V4_CMD   = 5'd1,
      PH_V4_PORT  = 5'd2,
      PH_V4_IP    = 5'd3,
      PH_V4_USER  = 5'd4,
      PH_V4A_DOM  = 5'd5,
      PH_V5_NMETH = 5'd6,
      PH_V5_METH  = 5'd7,
      PH_V5_VER   = 5'd8,
      PH_V5_CMD   = 5'd9,
      PH_V5_RSV   = 5'd10,
      PH_V5_ATYP  = 5'd11,
      PH_V5_DLEN  = 5'd12,
      PH_V5_ADDR  = 5'd13,
      PH_V5_PORT  = 5'd14,
      PH_DONE     = 5'd15,
      PH_ERROR    = 5'd16
   } phase_type;

endpackage

`default_nettype wire

/* hw/rtl/srp_req_if.sv */
// Request channel of the SOCKS request parser: valid/ready plus one client byte.
// Depends on nothing.
`default_nettype none

interface srp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

/* hw/rtl/srp_rsp_if.sv */
// Result channel of the SOCKS request parser: valid/ready plus one result.
// Depends on srp_pkg for the status type.
`default_nettype none

interface srp_rsp_if import srp_pkg::*; ;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [2:0]  socks_version;
   logic [2:0]  address_type;
   logic [7:0]  addr_byte;
   logic        addr_byte_valid;
   logic [7:0]  addr_byte_index;
   logic [15:0] dest_port;
   logic [7:0]  payload_byte;

   modport source (output valid, output status, output socks_version,
                   output address_type, output addr_byte, output addr_byte_valid,
                   output addr_byte_index, output dest_port, output payload_byte,
                   input ready);
   modport sink   (input valid, input status, input socks_version,
                   input address_type, input addr_byte, input addr_byte_valid,
                   input addr_byte_index, input dest_port, input payload_byte,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/socks_request_parser.sv */
// SOCKS4 / SOCKS4a / SOCKS5 client handshake parser, one byte per transaction.
// Depends on srp_pkg, srp_req_if, srp_rsp_if and assert_macros.svh.
//
// Each request transaction carries one byte of the client stream; start_req
// marks the first byte of a new connection and clears all parse state. Every
// byte yields exactly one result transaction with a status (consumed, methods
// accepted, request complete, error, payload), the version seen, the address
// kind, an address byte with its index when one arrived, the port assembled
// so far and, after completion, the byte passed through as payload. Once in
// error the parser answers error until the next start_req. Throughput is one
// byte per clock: the phase machine update is a single level of compare and
// select logic feeding the result register, and a new byte is accepted
// whenever that register is empty or being drained in the same cycle. The
// result is valid in the cycle after request acceptance. If the result side
// stalls, the request side stalls with it.
`default_nettype none
`include "assert_macros.svh"

module socks_request_parser import srp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   srp_req_if.sink   req_channel,
   srp_rsp_if.source rsp_channel
);

   // parse state
   phase_type   phase_ff, phase_in;
   logic        version_seen_ff, version_seen_in;
   logic        is_v5_ff, is_v5_in;
   logic [7:0]  field_counter_ff, field_counter_in;
   logic [7:0]  methods_left_ff, methods_left_in;
   logic        noauth_seen_ff, noauth_seen_in;
   logic [2:0]  addr_kind_ff, addr_kind_in;
   logic [7:0]  addr_left_ff, addr_left_in;
   logic [15:0] port_value_ff, port_value_in;
   logic        ipv4_prefix_zero_ff, ipv4_prefix_zero_in;
   logic [7:0]  ipv4_last_byte_ff, ipv4_last_byte_in;

   // result register
   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic [2:0]  version_ff;
   logic [2:0]  atype_ff;
   logic [7:0]  abyte_ff, abyte_in;
   logic        avalid_ff, avalid_in;
   logic [7:0]  aidx_ff, aidx_in;
   logic [15:0] port_ff;
   logic [7:0]  pbyte_ff, pbyte_in;

   // state as seen by this byte (start_req restarts from reset values)
   phase_type   cur_phase;
   logic [7:0]  cur_field_counter;
   logic [7:0]  cur_methods_left;
   logic        cur_noauth_seen;
   logic [2:0]  cur_addr_kind;
   logic [15:0] cur_port_value;
   logic        cur_ipv4_prefix_zero;
   logic [7:0]  cur_ipv4_last_byte;
   logic        cur_version_seen;
   logic        cur_is_v5;
   logic [7:0]  cur_addr_left;

   logic [7:0]  b;
   logic [7:0]  counter_inc;
   logic [7:0]  methods_dec;
   logic [7:0]  addr_left_dec;
   logic        req_accept;

   assign b          = req_channel.data_byte;
   assign req_accept = req_channel.valid && req_channel.ready;

   // result register drains or is empty: take a new byte
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;

   always_comb begin
      if (req_channel.start_req) begin
         cur_phase            = PH_IDLE;
         cur_version_seen     = 1'b0;
         cur_is_v5            = 1'b0;
         cur_field_counter    = '0;
         cur_methods_left     = '0;
         cur_noauth_seen      = 1'b0;
         cur_addr_kind        = ATYP_UNKNOWN;
         cur_addr_left        = '0;
         cur_port_value       = '0;
         cur_ipv4_prefix_zero = 1'b1;
         cur_ipv4_last_byte   = '0;
      end else begin
         cur_phase            = phase_ff;
         cur_version_seen     = version_seen_ff;
         cur_is_v5            = is_v5_ff;
         cur_field_counter    = field_counter_ff;
         cur_methods_left     = methods_left_ff;
         cur_noauth_seen      = noauth_seen_ff;
         cur_addr_kind        = addr_kind_ff;
         cur_addr_left        = addr_left_ff;
         cur_port_value       = port_value_ff;
         cur_ipv4_prefix_zero = ipv4_prefix_zero_ff;
         cur_ipv4_last_byte   = ipv4_last_byte_ff;
      end
   end

   assign counter_inc   = cur_field_counter + 8'd1;
   assign methods_dec   = cur_methods_left - 8'd1;
   assign addr_left_dec = cur_addr_left - 8'd1;

   // phase machine: one step per byte
   always_comb begin
      phase_in            = cur_phase;
      version_seen_in     = cur_version_seen;
      is_v5_in            = cur_is_v5;
      field_counter_in    = cur_field_counter;
      methods_left_in     = cur_methods_left;
      noauth_seen_in      = cur_noauth_seen;
      addr_kind_in        = cur_addr_kind;
      addr_left_in        = cur_addr_left;
      port_value_in       = cur_port_value;
      ipv4_prefix_zero_in = cur_ipv4_prefix_zero;
      ipv4_last_byte_in   = cur_ipv4_last_byte;
      status_in           = ST_CONSUMED;
      abyte_in            = '0;
      avalid_in           = 1'b0;
      aidx_in             = '0;
      pbyte_in            = '0;

      case (cur_phase)
         PH_IDLE: begin
            if (b == BYTE_VER4) begin
               version_seen_in = 1'b1;
               is_v5_in        = 1'b0;
               phase_in        = PH_V4_CMD;
            end else if (b == BYTE_VER5) begin
               version_seen_in = 1'b1;
               is_v5_in        = 1'b1;
               phase_in        = PH_V5_NMETH;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_V4_CMD: begin
            if (b == BYTE_CMD_CONNECT) begin
               field_counter_in = '0;
               phase_in         = PH_V4_PORT;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_V4_PORT, PH_V5_PORT: begin
            port_value_in    = {cur_port_value[7:0], b};
            field_counter_in = counter_inc;
            if (counter_inc >= PORT_BYTES) begin
               if (cur_phase == PH_V4_PORT) begin
                  field_counter_in = '0;
                  phase_in         = PH_V4_IP;
               end else begin
                  status_in = ST_COMPLETE;
                  phase_in  = PH_DONE;
               end
            end
         end
         PH_V4_IP: begin
            abyte_in  = b;
            avalid_in = 1'b1;
            aidx_in   = cur_field_counter;
            if (cur_field_counter < IPV4_PREFIX_LEN) begin
               if (b != BYTE_ZERO) begin
                  ipv4_prefix_zero_in = 1'b0;
               end
            end else begin
               ipv4_last_byte_in = b;
            end
            field_counter_in = counter_inc;
            if (counter_inc >= IPV4_ADDR_LEN) begin
               phase_in = PH_V4_USER;
            end
         end
         PH_V4_USER: begin
            // only an empty user id; 0.0.0.x with x nonzero selects 4a
            if (b != BYTE_ZERO) begin
               phase_in = PH_ERROR;
            end else if (cur_ipv4_prefix_zero && (cur_ipv4_last_byte != BYTE_ZERO)) begin
               addr_kind_in     = ATYP_DOMAIN;
               field_counter_in = '0;
               phase_in         = PH_V4A_DOM;
            end else begin
               addr_kind_in = ATYP_IPV4;
               status_in    = ST_COMPLETE;
               phase_in     = PH_DONE;
            end
         end
         PH_V4A_DOM: begin
            if (b == BYTE_ZERO) begin
               status_in = ST_COMPLETE;
               phase_in  = PH_DONE;
            end else begin
               abyte_in         = b;
               avalid_in        = 1'b1;
               aidx_in          = cur_field_counter;
               field_counter_in = counter_inc;
            end
         end
         PH_V5_NMETH: begin
            if (b == BYTE_ZERO) begin
               phase_in = PH_ERROR;
            end else begin
               methods_left_in = b;
               noauth_seen_in  = 1'b0;
               phase_in        = PH_V5_METH;
            end
         end
         PH_V5_METH: begin
            if (b == BYTE_NOAUTH) begin
               noauth_seen_in = 1'b1;
            end
            methods_left_in = methods_dec;
            if (methods_dec == '0) begin
               if (cur_noauth_seen || (b == BYTE_NOAUTH)) begin
                  status_in = ST_METHODS;
                  phase_in  = PH_V5_VER;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
         end
         PH_V5_VER: begin
            phase_in = (b == BYTE_VER5) ? PH_V5_CMD : PH_ERROR;
         end
         PH_V5_CMD: begin
            phase_in = (b == BYTE_CMD_CONNECT) ? PH_V5_RSV : PH_ERROR;
         end
         PH_V5_RSV: begin
            phase_in = PH_V5_ATYP;
         end
         PH_V5_ATYP: begin
            field_counter_in = '0;
            if (b == BYTE_ATYP_IPV4) begin
               addr_kind_in = ATYP_IPV4;
               addr_left_in = IPV4_ADDR_LEN;
               phase_in     = PH_V5_ADDR;
            end else if (b == BYTE_ATYP_IPV6) begin
               addr_kind_in = ATYP_IPV6;
               addr_left_in = IPV6_ADDR_LEN;
               phase_in     = PH_V5_ADDR;
            end else if (b == BYTE_ATYP_DOMAIN) begin
               addr_kind_in = ATYP_DOMAIN;
               phase_in     = PH_V5_DLEN;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_V5_DLEN: begin
            // zero-length domain goes straight to the port
            addr_left_in     = b;
            field_counter_in = '0;
            phase_in         = (b == BYTE_ZERO) ? PH_V5_PORT : PH_V5_ADDR;
         end
         PH_V5_ADDR: begin
            abyte_in         = b;
            avalid_in        = 1'b1;
            aidx_in          = cur_field_counter;
            field_counter_in = counter_inc;
            addr_left_in     = addr_left_dec;
            if (addr_left_dec == '0) begin
               field_counter_in = '0;
               phase_in         = PH_V5_PORT;
            end
         end
         PH_DONE: begin
            status_in = ST_PAYLOAD;
            pbyte_in  = b;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      if (phase_in == PH_ERROR) begin
         status_in = ST_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         version_seen_ff     <= 1'b0;
         is_v5_ff            <= 1'b0;
         field_counter_ff    <= '0;
         methods_left_ff     <= '0;
         noauth_seen_ff      <= 1'b0;
         addr_kind_ff        <= ATYP_UNKNOWN;
         addr_left_ff        <= '0;
         port_value_ff       <= '0;
         ipv4_prefix_zero_ff <= 1'b1;
         ipv4_last_byte_ff   <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff            <= phase_in;
            version_seen_ff     <= version_seen_in;
            is_v5_ff            <= is_v5_in;
            field_counter_ff    <= field_counter_in;
            methods_left_ff     <= methods_left_in;
            noauth_seen_ff      <= noauth_seen_in;
            addr_kind_ff        <= addr_kind_in;
            addr_left_ff        <= addr_left_in;
            port_value_ff       <= port_value_in;
            ipv4_prefix_zero_ff <= ipv4_prefix_zero_in;
            ipv4_last_byte_ff   <= ipv4_last_byte_in;
            rsp_valid_ff        <= 1'b1;
            // result payload, loaded with each accepted byte
            status_ff  <= status_in;
            version_ff <= version_seen_in ? (is_v5_in ? VER_5 : VER_4) : VER_NONE;
            atype_ff   <= addr_kind_in;
            abyte_ff   <= abyte_in;
            avalid_ff  <= avalid_in;
            aidx_ff    <= aidx_in;
            port_ff    <= port_value_in;
            pbyte_ff   <= pbyte_in;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_channel.valid           = rsp_valid_ff;
   assign rsp_channel.status          = status_ff;
   assign rsp_channel.socks_version   = version_ff;
   assign rsp_channel.address_type    = atype_ff;
   assign rsp_channel.addr_byte       = abyte_ff;
   assign rsp_channel.addr_byte_valid = avalid_ff;
   assign rsp_channel.addr_byte_index = aidx_ff;
   assign rsp_channel.dest_port       = port_ff;
   assign rsp_channel.payload_byte    = pbyte_ff;

   // address bytes only ever come with a plain consumed status
   `ASSERT_PROP(a_addr_consumed, clock, reset,
      (rsp_valid_ff && avalid_ff) |-> (status_ff == ST_CONSUMED))

   // payload byte is zero outside the payload phase
   `ASSERT_NEVER(a_payload_only, clock, reset,
      rsp_valid_ff && (status_ff != ST_PAYLOAD) && (pbyte_ff != 8'd0))

   // error is sticky until a new connection starts
   `ASSERT_PROP(a_error_sticky, clock, reset,
      (req_accept && (phase_ff == PH_ERROR) && !req_channel.start_req)
         |=> (rsp_valid_ff && (status_ff == ST_ERROR)))

   // a completed request always carries a known version
   `ASSERT_PROP(a_complete_version, clock, reset,
      (rsp_valid_ff && (status_ff == ST_COMPLETE))
         |-> ((version_ff == VER_4) || (version_ff == VER_5)))

endmodule

`default_nettype wire
